FILE: src/imu_pd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_pd_pkg
// Shared constants and types of the IMU packet deframer.
// ----------------------------------------------------------------------------
package imu_pd_pkg;

  localparam int PacketBytes = 40;                    // 40 .. 255
  localparam int WindowLen   = PacketBytes + 2;
  localparam int SeenW       = $clog2(WindowLen + 1);
  localparam int PosW        = $clog2(PacketBytes);

  typedef logic [7:0] byte_t;

  typedef enum logic {
    ST_HUNT,
    ST_LOCKED
  } sync_state_t;

  typedef struct packed {
    logic locked;
    logic emit_due;   // next accepted item completes a packet
  } sync_status_t;

endpackage

FILE: src/imu_pd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_pd_cell
// One byte of the sliding window; loads its neighbour's byte on advance.
// ----------------------------------------------------------------------------
module imu_pd_cell (
  input  logic             clk,
  input  logic             advance,
  input  imu_pd_pkg::byte_t d,
  output imu_pd_pkg::byte_t q
);

  always_ff @(posedge clk) begin
    if (advance) begin
      q <= d;
    end
  end

endmodule

FILE: src/imu_pd_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_pd_sync
// Lock search on the window ends and packet position counting after lock.
// ----------------------------------------------------------------------------
module imu_pd_sync (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  imu_pd_pkg::byte_t         sync_byte,
  input  imu_pd_pkg::byte_t         head_byte,    // becomes oldest byte
  input  imu_pd_pkg::byte_t         count_byte,   // becomes second byte
  input  imu_pd_pkg::byte_t         rx_byte,      // becomes newest byte
  output imu_pd_pkg::sync_status_t  status
);

  imu_pd_pkg::sync_state_t      state, state_next;
  logic [imu_pd_pkg::SeenW-1:0] seen, seen_next;
  logic [imu_pd_pkg::PosW-1:0]  pos, pos_next;
  logic                         full_next;
  logic                         match;
  logic                         pos_last;
  imu_pd_pkg::byte_t            count_inc;

  assign count_inc = count_byte + 8'd1;
  assign full_next = seen >= imu_pd_pkg::SeenW'(imu_pd_pkg::WindowLen - 1);
  assign match     = full_next && (head_byte == sync_byte) && (rx_byte == count_inc);
  assign pos_last  = pos == imu_pd_pkg::PosW'(imu_pd_pkg::PacketBytes - 1);

  always_comb begin
    state_next = state;
    case (state)
      imu_pd_pkg::ST_HUNT: begin
        if (advance && match) begin
          state_next = imu_pd_pkg::ST_LOCKED;
        end
      end
      imu_pd_pkg::ST_LOCKED: state_next = imu_pd_pkg::ST_LOCKED;
      default:               state_next = imu_pd_pkg::ST_HUNT;
    endcase
  end

  always_comb begin
    seen_next = seen;
    pos_next  = pos;
    if (advance) begin
      if (seen != imu_pd_pkg::SeenW'(imu_pd_pkg::WindowLen)) begin
        seen_next = seen + 1'b1;
      end
      case (state)
        imu_pd_pkg::ST_HUNT:   pos_next = imu_pd_pkg::PosW'(2);
        imu_pd_pkg::ST_LOCKED: pos_next = pos_last ? '0 : pos + 1'b1;
        default:               pos_next = pos;
      endcase
    end
  end

  always_comb begin
    status.locked   = 1'b0;
    status.emit_due = 1'b0;
    case (state)
      imu_pd_pkg::ST_HUNT: ;
      imu_pd_pkg::ST_LOCKED: begin
        status.locked   = 1'b1;
        status.emit_due = pos_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imu_pd_pkg::ST_HUNT;
      seen  <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
      pos   <= pos_next;
    end
  end

endmodule

FILE: src/imu_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_deframer
// Sync-word deframer for fixed-size IMU packets over a sliding byte window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one received byte per item.
//   Output channel out_valid/out_ready carries one decoded packet per item:
//   counter, length and nine raw IEEE single words.
//   cfg_wr_en/cfg_wr_data set the sync byte; write it while idle.
//   One byte is taken per cycle while in_ready is high; the window is a row of
//   byte cells that all shift on each accepted item. A packet is presented in
//   the cycle after the item carrying its last byte, from the output register.
//   After reset the window is empty and the block hunts for the sync byte
//   followed one packet later by the next counter; that first packet is
//   dropped, then every PacketBytes bytes yield one packet.
//   While a packet waits on a stalled receiver, bytes are still taken; only
//   a byte that would complete the next packet is held off (in_ready low).
//   Reset clears lock, fill and position state and the output valid.
// ----------------------------------------------------------------------------
module imu_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_counter,
  output logic [15:0] packet_length,
  output logic [31:0] accel_x_bits,
  output logic [31:0] accel_y_bits,
  output logic [31:0] accel_z_bits,
  output logic [31:0] rate_x_bits,
  output logic [31:0] rate_y_bits,
  output logic [31:0] rate_z_bits,
  output logic [31:0] roll_bits,
  output logic [31:0] pitch_bits,
  output logic [31:0] yaw_bits
);

  localparam int Wl = imu_pd_pkg::WindowLen;

  imu_pd_pkg::byte_t        win      [Wl];
  imu_pd_pkg::byte_t        win_next [Wl];
  imu_pd_pkg::byte_t        sync_byte;
  imu_pd_pkg::sync_status_t sts;
  logic                     advance;
  logic                     emit;

  assign in_ready = !(sts.emit_due && out_valid && !out_ready);
  assign advance  = in_valid && in_ready;
  assign emit     = advance && sts.emit_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= '0;
    end else if (cfg_wr_en) begin
      sync_byte <= cfg_wr_data;
    end
  end

  genvar g;
  generate
    for (g = 0; g < Wl; g++) begin : g_cell
      if (g == Wl - 1) begin : g_tail
        assign win_next[g] = rx_byte;
      end else begin : g_body
        assign win_next[g] = win[g+1];
      end
      imu_pd_cell u_cell (
        .clk     (clk),
        .advance (advance),
        .d       (win_next[g]),
        .q       (win[g])
      );
    end
  endgenerate

  imu_pd_sync u_sync (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .sync_byte  (sync_byte),
    .head_byte  (win[1]),
    .count_byte (win[2]),
    .rx_byte    (rx_byte),
    .status     (sts)
  );

  // packet byte i sits at window slot 2 + i once this item is shifted in
  function automatic logic [31:0] pkt_word(input imu_pd_pkg::byte_t b0,
                                           input imu_pd_pkg::byte_t b1,
                                           input imu_pd_pkg::byte_t b2,
                                           input imu_pd_pkg::byte_t b3);
    return {b1, b0, b3, b2};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packet_counter <= win_next[3];
      packet_length  <= {win_next[5], win_next[4]};
      accel_x_bits   <= pkt_word(win_next[6],  win_next[7],  win_next[8],  win_next[9]);
      accel_y_bits   <= pkt_word(win_next[10], win_next[11], win_next[12], win_next[13]);
      accel_z_bits   <= pkt_word(win_next[14], win_next[15], win_next[16], win_next[17]);
      rate_x_bits    <= pkt_word(win_next[18], win_next[19], win_next[20], win_next[21]);
      rate_y_bits    <= pkt_word(win_next[22], win_next[23], win_next[24], win_next[25]);
      rate_z_bits    <= pkt_word(win_next[26], win_next[27], win_next[28], win_next[29]);
      roll_bits      <= pkt_word(win_next[30], win_next[31], win_next[32], win_next[33]);
      pitch_bits     <= pkt_word(win_next[34], win_next[35], win_next[36], win_next[37]);
      yaw_bits       <= pkt_word(win_next[38], win_next[39], win_next[40], win_next[41]);
    end
  end

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("completed packet not presented");

  a_lock_kept: assert property (@(posedge clk) disable iff (rst)
    sts.locked |=> sts.locked)
    else $error("lock lost");

  a_due_locked: assert property (@(posedge clk) disable iff (rst)
    sts.emit_due |-> sts.locked)
    else $error("packet due while hunting");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && advance) |-> !sts.emit_due)
    else $error("waiting packet overwritten");

endmodule
